>>> sv/trfc_pkg.sv
`timescale 1ns / 1ps
package trfc_pkg;

    localparam int unsigned TICK_W  = 32;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        MODE_SEMI = 2'd0,
        MODE_RAMP = 2'd1,
        MODE_AUTO = 2'd2,
        MODE_IDLE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EDGE_NONE    = 2'd0,
        EDGE_PULL    = 2'd1,
        EDGE_RELEASE = 2'd2,
        EDGE_UNUSED  = 2'd3
    } t_edge;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIRING_MODE       = 2'd0,
        REG_KICKIN_INTERVAL   = 2'd1,
        REG_KICKIN_PULLS      = 2'd2,
        REG_MAX_RATE_INTERVAL = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]        trigger_edge;
        logic [TICK_W-1:0] now_ticks;
        logic [TICK_W-1:0] pull_stamp;
        logic [TICK_W-1:0] solenoid_start;
    } t_in_item;

    typedef struct packed {
        logic               fire;
        logic               ramp_active;
        logic [COUNT_W-1:0] fast_pull_count;
    } t_out_item;

endpackage

>>> sv/trfc_in_if.sv
`timescale 1ns / 1ps
interface trfc_in_if;
    logic                valid;
    logic                ready;
    trfc_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/trfc_out_if.sv
`timescale 1ns / 1ps
interface trfc_out_if;
    logic                valid;
    logic                ready;
    trfc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/trigger_ramp_fire_controller_top.sv
`timescale 1ns / 1ps
// Path: an accepted input beat is held in the input register, and its result is
//   then written to the result register when that beat moves on.
// Throughput: one beat per cycle; the input register and the result register
//   each advance when the stage after them is empty or drains in the same cycle.
// Reset (i_rst_n low, synchronous): clears both valid flags, the ramp state,
//   the pull count, the previous pull tick and all configuration registers.
module trigger_ramp_fire_controller_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [trfc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [trfc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    trfc_in_if.sink                           i_in,
    trfc_out_if.source                        o_out
);
    import trfc_pkg::*;

    t_mode              r_mode;
    logic [TICK_W-1:0]  r_kickin_interval;
    logic [COUNT_W-1:0] r_kickin_pulls;
    logic [TICK_W-1:0]  r_max_rate_interval;

    logic               r_s1_valid;
    t_in_item           r_s1_item;

    logic               r_ramp_on;
    logic [COUNT_W-1:0] r_pull_count;
    logic [TICK_W-1:0]  r_previous_pull;
    logic               n_ramp_on;
    logic [COUNT_W-1:0] n_pull_count;
    logic [TICK_W-1:0]  n_previous_pull;
    logic               n_fire;

    logic               r_out_valid;
    t_out_item          r_out_item;

    logic               w_s1_move;
    logic               w_in_ready;
    logic               w_pulled;
    logic [TICK_W-1:0]  w_gap;
    logic [TICK_W-1:0]  w_expire_tick;
    logic [TICK_W-1:0]  w_next_shot_tick;
    logic [COUNT_W-1:0] w_count_pull;
    logic [COUNT_W-1:0] w_count_final;

    assign w_s1_move  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign w_in_ready = !r_s1_valid || w_s1_move;
    assign i_in.ready = w_in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode              <= MODE_SEMI;
            r_kickin_interval   <= '0;
            r_kickin_pulls      <= '0;
            r_max_rate_interval <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIRING_MODE:       r_mode <= t_mode'(i_cfg_data[1:0]);
                REG_KICKIN_INTERVAL:   r_kickin_interval <= i_cfg_data[TICK_W-1:0];
                REG_KICKIN_PULLS:      r_kickin_pulls <= i_cfg_data[COUNT_W-1:0];
                REG_MAX_RATE_INTERVAL: r_max_rate_interval <= i_cfg_data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_pulled         = (r_s1_item.trigger_edge == EDGE_PULL);
        w_gap            = r_s1_item.pull_stamp - r_previous_pull;
        w_expire_tick    = r_s1_item.pull_stamp + r_kickin_interval;
        w_next_shot_tick = r_s1_item.solenoid_start + r_max_rate_interval;

        w_count_pull = r_pull_count;
        if (w_pulled) begin
            if (w_gap <= r_kickin_interval) begin
                w_count_pull = (r_pull_count == COUNT_MAX) ? r_pull_count
                                                           : r_pull_count + 1'b1;
            end else begin
                w_count_pull = '0;
            end
        end
        w_count_final = (r_s1_item.now_ticks > w_expire_tick) ? '0 : w_count_pull;
    end

    always_comb begin
        n_fire          = 1'b0;
        n_ramp_on       = r_ramp_on;
        n_pull_count    = r_pull_count;
        n_previous_pull = r_previous_pull;
        case (r_mode)
            MODE_SEMI, MODE_AUTO: begin
                n_fire = w_pulled;
            end
            MODE_RAMP: begin
                n_pull_count = w_count_final;
                if (w_pulled) begin
                    n_previous_pull = r_s1_item.pull_stamp;
                end
                if (!r_ramp_on) begin
                    n_fire    = w_pulled;
                    n_ramp_on = (w_count_final >= r_kickin_pulls);
                end else begin
                    n_fire    = (r_s1_item.now_ticks >= w_next_shot_tick);
                    n_ramp_on = (w_count_final != '0);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_ramp_on       <= 1'b0;
            r_pull_count    <= '0;
            r_previous_pull <= '0;
        end else begin
            if (w_in_ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (w_s1_move) begin
                r_out_valid     <= 1'b1;
                r_ramp_on       <= n_ramp_on;
                r_pull_count    <= n_pull_count;
                r_previous_pull <= n_previous_pull;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_s1_item <= i_in.data;
        end
        if (w_s1_move) begin
            r_out_item.fire            <= n_fire;
            r_out_item.ramp_active     <= n_ramp_on;
            r_out_item.fast_pull_count <= n_pull_count;
        end
    end

    a_ramp_rises_in_ramp_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ramp_on) |-> ($past(r_mode) == MODE_RAMP))
        else $error("ramp state set outside ramp mode");

    a_count_moves_with_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_pull_count)) |-> $past(w_s1_move))
        else $error("pull count changed without a beat");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> w_in_ready)
        else $error("input stalled while result register empty");

    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(w_s1_move)) |->
            (r_out_item.ramp_active == r_ramp_on &&
             r_out_item.fast_pull_count == r_pull_count))
        else $error("result disagrees with updated state");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
import trfc_pkg::*;

class fire_decision_board;
    t_mode           mode;
    logic [31:0]     kick_intv;
    logic [7:0]      kick_pulls;
    logic [31:0]     rate_intv;
    bit              ramp_on;
    bit [7:0]        pull_cnt;
    bit [31:0]       last_pull;
    t_out_item       decisions_due[$];
    int              mismatches;

    function new();
        clear();
        mismatches = 0;
    endfunction

    function void clear();
        mode       = MODE_SEMI;
        kick_intv  = '0;
        kick_pulls = '0;
        rate_intv  = '0;
        ramp_on    = 1'b0;
        pull_cnt   = '0;
        last_pull  = '0;
        decisions_due.delete();
    endfunction

    function void set_reg(t_reg_idx idx, logic [31:0] val);
        case (idx)
            REG_FIRING_MODE:       mode = t_mode'(val[1:0]);
            REG_KICKIN_INTERVAL:   kick_intv = val;
            REG_KICKIN_PULLS:      kick_pulls = val[7:0];
            REG_MAX_RATE_INTERVAL: rate_intv = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return decisions_due.size();
    endfunction

    function void note_tick(t_in_item it);
        bit        pulled;
        bit        shot;
        bit [31:0] gap;
        bit [31:0] pull_limit;
        bit [31:0] shot_due;
        t_out_item exp_item;
        pulled = (it.trigger_edge == EDGE_PULL);
        shot = 1'b0;
        case (mode)
            MODE_SEMI, MODE_AUTO: shot = pulled;
            MODE_RAMP: begin
                if (pulled) begin
                    gap = it.pull_stamp - last_pull;
                    if (gap <= kick_intv) begin
                        if (pull_cnt != COUNT_MAX)
                            pull_cnt = pull_cnt + 8'd1;
                    end else begin
                        pull_cnt = '0;
                    end
                    last_pull = it.pull_stamp;
                end
                pull_limit = it.pull_stamp + kick_intv;
                if (it.now_ticks > pull_limit)
                    pull_cnt = '0;
                if (!ramp_on) begin
                    shot = pulled;
                    if (pull_cnt >= kick_pulls)
                        ramp_on = 1'b1;
                end else begin
                    shot_due = it.solenoid_start + rate_intv;
                    shot = (it.now_ticks >= shot_due);
                    if (pull_cnt == 8'd0)
                        ramp_on = 1'b0;
                end
            end
            default: ;
        endcase
        exp_item.fire            = shot;
        exp_item.ramp_active     = ramp_on;
        exp_item.fast_pull_count = pull_cnt;
        decisions_due.push_back(exp_item);
    endfunction

    function void check_decision(t_out_item got);
        t_out_item exp_item;
        if (decisions_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: fire=%0b ramp=%0b count=%0d",
                         got.fire, got.ramp_active, got.fast_pull_count);
            return;
        end
        exp_item = decisions_due.pop_front();
        if (got.fire !== exp_item.fire || got.ramp_active !== exp_item.ramp_active ||
            got.fast_pull_count !== exp_item.fast_pull_count) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected fire=%0b ramp=%0b count=%0d, got fire=%0b ramp=%0b count=%0d",
                         exp_item.fire, exp_item.ramp_active, exp_item.fast_pull_count,
                         got.fire, got.ramp_active, got.fast_pull_count);
        end
    endfunction
endclass

module tb_top;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    trfc_in_if  in_bus();
    trfc_out_if out_bus();

    trigger_ramp_fire_controller_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_bus),
        .o_out      (out_bus)
    );

    fire_decision_board board;
    int unsigned cycles;
    int          send_run;
    int          take_run;

    bit [31:0] tl_now;
    bit [31:0] tl_stamp;
    int unsigned step_max;
    int unsigned sol_span;
    int unsigned pull_pct;

    initial begin
        i_clk = 1'b0;
    end
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("trigger_ramp_fire_controller_top verification failed");
        $finish;
    end

    function automatic int draw_gap(ref int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            run_left = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    function automatic t_in_item mk(t_edge e, bit [31:0] now, bit [31:0] stamp,
                                    bit [31:0] sol);
        t_in_item it;
        it.trigger_edge   = e;
        it.now_ticks      = now;
        it.pull_stamp     = stamp;
        it.solenoid_start = sol;
        return it;
    endfunction

    function automatic t_in_item next_tick();
        t_in_item    it;
        int unsigned r;
        if ($urandom_range(0, 99) < 12) begin
            it.trigger_edge   = 2'($urandom_range(0, 3));
            it.now_ticks      = $urandom;
            it.pull_stamp     = $urandom;
            it.solenoid_start = $urandom;
            return it;
        end
        tl_now = tl_now + $urandom_range(0, step_max);
        if ($urandom_range(0, 99) < pull_pct) begin
            tl_stamp = tl_now - $urandom_range(0, 2);
            it.trigger_edge = EDGE_PULL;
        end else begin
            r = $urandom_range(0, 9);
            it.trigger_edge = (r < 7) ? EDGE_NONE : (r < 9) ? EDGE_RELEASE : EDGE_UNUSED;
        end
        it.now_ticks      = tl_now;
        it.pull_stamp     = tl_stamp;
        it.solenoid_start = tl_now - $urandom_range(0, sol_span);
        return it;
    endfunction

    task automatic send_beat(t_in_item it);
        int gap;
        gap = draw_gap(send_run);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.data  <= it;
        do @(posedge i_clk); while (!in_bus.ready);
        board.note_tick(it);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_bus.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_config(t_mode m, bit [31:0] intv, bit [7:0] pulls, bit [31:0] rate);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_FIRING_MODE;
        i_cfg_data <= 32'(m);
        board.set_reg(REG_FIRING_MODE, 32'(m));
        @(negedge i_clk);
        i_cfg_idx  <= REG_KICKIN_INTERVAL;
        i_cfg_data <= intv;
        board.set_reg(REG_KICKIN_INTERVAL, intv);
        @(negedge i_clk);
        i_cfg_idx  <= REG_KICKIN_PULLS;
        i_cfg_data <= 32'(pulls);
        board.set_reg(REG_KICKIN_PULLS, 32'(pulls));
        @(negedge i_clk);
        i_cfg_idx  <= REG_MAX_RATE_INTERVAL;
        i_cfg_data <= rate;
        board.set_reg(REG_MAX_RATE_INTERVAL, rate);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_phase(int n_items);
        t_mode       m;
        bit [31:0]   intv;
        bit [7:0]    pulls;
        bit [31:0]   rate;
        int unsigned r;
        r = $urandom_range(0, 9);
        m = (r < 6) ? MODE_RAMP : (r == 6) ? MODE_SEMI : (r == 7) ? MODE_AUTO :
            (r == 8) ? MODE_IDLE : t_mode'($urandom_range(0, 3));
        r = $urandom_range(0, 9);
        intv = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? $urandom :
               $urandom_range(1, 300);
        r = $urandom_range(0, 9);
        pulls = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : (r == 2) ? 8'($urandom_range(0, 255)) :
                8'($urandom_range(1, 6));
        r = $urandom_range(0, 9);
        rate = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : (r == 2) ? $urandom :
               $urandom_range(1, 60);
        drain();
        set_config(m, intv, pulls, rate);
        step_max = (intv > 2000) ? $urandom_range(1, 2000) : intv / 2 + $urandom_range(1, 4);
        sol_span = (rate > 100) ? 200 : 2 * rate + 2;
        pull_pct = $urandom_range(25, 60);
        tl_now   = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FE00 + $urandom_range(0, 255) :
                   $urandom;
        tl_stamp = tl_now;
        repeat (n_items) send_beat(next_tick());
    endtask

    initial begin
        board = new();
        out_bus.ready = 1'b0;
        take_run = 0;
        @(posedge i_rst_n);
        forever begin
            int gap;
            gap = draw_gap(take_run);
            @(negedge i_clk);
            if (gap > 0) begin
                out_bus.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!out_bus.valid);
            board.check_decision(out_bus.data);
        end
    end

    initial begin
        cycles       = 0;
        send_run     = 0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        in_bus.valid = 1'b0;
        in_bus.data  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // semi mode straight out of reset
        send_beat(mk(EDGE_NONE, 32'd0, 32'd0, 32'd0));
        send_beat(mk(EDGE_PULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_beat(mk(EDGE_RELEASE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
        send_beat(mk(EDGE_UNUSED, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));

        // ramp kick-in, max-rate shots, drop out on an expired interval
        drain();
        set_config(MODE_RAMP, 32'd100, 8'd2, 32'd10);
        send_beat(mk(EDGE_PULL, 32'd1000, 32'd1000, 32'd0));
        send_beat(mk(EDGE_PULL, 32'd1050, 32'd1050, 32'd1000));
        send_beat(mk(EDGE_UNUSED, 32'd1060, 32'd1060, 32'd1050));
        send_beat(mk(EDGE_PULL, 32'd1080, 32'd1080, 32'd1050));
        send_beat(mk(EDGE_NONE, 32'd1085, 32'd1080, 32'd1080));
        send_beat(mk(EDGE_RELEASE, 32'd1095, 32'd1080, 32'd1080));
        send_beat(mk(EDGE_NONE, 32'd1200, 32'd1080, 32'd1080));
        // sums that wrap past the top of the tick range
        send_beat(mk(EDGE_PULL, 32'hFFFF_FFF5, 32'hFFFF_FFF0, 32'hFFFF_FFF0));
        send_beat(mk(EDGE_NONE, 32'h0000_0010, 32'hFFFF_FFF0, 32'hFFFF_FFFA));

        // zero threshold: ramp without a pull
        drain();
        set_config(MODE_RAMP, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF);
        send_beat(mk(EDGE_NONE, 32'd20, 32'd10, 32'd5));
        send_beat(mk(EDGE_PULL, 32'd30, 32'd30, 32'd5));

        drain();
        set_config(MODE_IDLE, 32'd50, 8'd3, 32'd5);
        send_beat(mk(EDGE_PULL, 32'd40, 32'd40, 32'd0));

        drain();
        set_config(MODE_AUTO, 32'd0, 8'd255, 32'd0);
        send_beat(mk(EDGE_PULL, 32'd50, 32'd50, 32'd0));
        send_beat(mk(EDGE_NONE, 32'd60, 32'd50, 32'd0));

        repeat (10) random_phase(80);

        // long run of fast pulls with the kick-in threshold at the count's maximum
        drain();
        set_config(MODE_RAMP, 32'd1000, 8'd255, 32'd5);
        step_max = 20;
        sol_span = 12;
        pull_pct = 85;
        tl_now   = $urandom;
        tl_stamp = tl_now;
        repeat (300) send_beat(next_tick());

        in_bus.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("trigger_ramp_fire_controller_top verification clean");
        end else begin
            $display("trigger_ramp_fire_controller_top verification failed");
        end
        $finish;
    end
endmodule

>>> sim.f
sv/trfc_pkg.sv
sv/trfc_in_if.sv
sv/trfc_out_if.sv
sv/trigger_ramp_fire_controller_top.sv
tb/tb_top.sv
